>>> rtl/sha1_pkg.sv
package sha1_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam int unsigned NumRounds = 80;
    localparam int unsigned NumDigestWords = 5;

    // Byte source for the block buffer
    typedef enum logic [1:0] {
        BSRC_DATA = 2'd0,
        BSRC_PAD  = 2'd1,
        BSRC_ZERO = 2'd2,
        BSRC_LEN  = 2'd3
    } byte_src_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      put_byte;     // write one byte at the current position
        byte_src_t src;
        logic      count_byte;   // add 8 to the bit count
        logic      latch_len;    // capture the bit count for the length field
        logic      comp_start;   // load working variables, round 0
        logic      comp_round;   // perform one round
        logic      comp_add;     // fold result into chaining words
        logic      out_load;     // digest word load (unused; digest_word is combinational)
        logic      restart;      // back to initial chaining values
    } sha1_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [5:0] pos;         // position of next byte
        logic       round_last;  // round 79 being executed
    } sha1_sts_t;

endpackage

>>> rtl/sha1_datapath.sv
module sha1_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha1_pkg::sha1_cmd_t cmd,
    input  logic [7:0]        data_byte,
    input  logic [2:0]        out_idx,
    output sha1_pkg::sha1_sts_t sts,
    output logic [31:0]       digest_word
);
    import sha1_pkg::*;

    logic [31:0] chain_reg [NumDigestWords];
    logic [31:0] w_reg [16];
    logic [63:0] count_reg;
    logic [63:0] len_reg;
    logic [5:0]  pos_reg;
    logic [6:0]  round_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [7:0]  byte_val;
    logic [2:0]  len_sel;
    logic [31:0] f_val, k_val, w_cur, w_new, t_val;

    // Select the byte to store
    always_comb begin
        len_sel = 3'd7 - pos_reg[2:0];
        case (cmd.src)
            BSRC_DATA: byte_val = data_byte;
            BSRC_PAD:  byte_val = 8'h80;
            BSRC_ZERO: byte_val = 8'h00;
            BSRC_LEN:  byte_val = len_reg[{len_sel, 3'b000} +: 8];
            default:   byte_val = 8'h00;
        endcase
    end

    // Round function; schedule kept in a 16-word sliding window
    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
        w_cur = (round_reg < 7'd16) ? w_reg[0] : w_new;
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;
    end

    // Block buffer: byte writes, and shift during rounds
    always_ff @(posedge aclk) begin
        if (cmd.put_byte) begin
            w_reg[pos_reg[5:2]][(5'd3 - {3'd0, pos_reg[1:0]}) * 8 +: 8] <= byte_val;
        end else if (cmd.comp_round) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_cur;
        end
    end

    // Working variables
    always_ff @(posedge aclk) begin
        if (cmd.comp_start) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (cmd.comp_round) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_len) begin
            len_reg <= count_reg;
        end
    end

    // Control state: counters and chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            chain_reg[0] <= H0;
            chain_reg[1] <= H1;
            chain_reg[2] <= H2;
            chain_reg[3] <= H3;
            chain_reg[4] <= H4;
            count_reg    <= '0;
            pos_reg      <= '0;
            round_reg    <= '0;
        end else begin
            if (cmd.put_byte) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.count_byte) begin
                count_reg <= count_reg + 64'd8;
            end
            if (cmd.comp_start) begin
                round_reg <= '0;
            end else if (cmd.comp_round) begin
                round_reg <= round_reg + 7'd1;
            end
            if (cmd.comp_add) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
        end
    end

    always_comb begin
        sts.pos        = pos_reg;
        sts.round_last = (round_reg == 7'(NumRounds - 1));
        case (out_idx)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

endmodule

>>> rtl/sha1_control.sv
module sha1_control (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_byte_present,
    input  logic              s_end_of_message,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_word_index,
    output logic              m_last_word,
    output sha1_pkg::sha1_cmd_t cmd,
    input  sha1_pkg::sha1_sts_t sts,
    output logic [2:0]        out_idx
);
    import sha1_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_START = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;       // first padding byte still to write
    logic       pad_reg, pad_next;       // padding in progress
    logic       lenw_reg, lenw_next;     // length bytes being written
    logic [2:0] idx_reg, idx_next;
    logic       mv_reg, mv_next;
    logic       acc;

    assign s_ready      = (state_reg == ST_IDLE);
    assign acc          = s_valid && s_ready;
    assign m_valid      = mv_reg;
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == 3'(NumDigestWords - 1));
    assign out_idx      = idx_reg;

    // Sequence bytes, padding, rounds and digest output
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        lenw_next  = lenw_reg;
        idx_next   = idx_reg;
        mv_next    = mv_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_byte_present) begin
                        cmd.put_byte   = 1'b1;
                        cmd.src        = BSRC_DATA;
                        cmd.count_byte = 1'b1;
                    end
                    if (s_end_of_message) begin
                        fin_next   = 1'b1;
                        pad_next   = 1'b1;
                        lenw_next  = 1'b0;
                        state_next = ST_PAD;
                    end
                    if (s_byte_present && sts.pos == 6'd63) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_PAD: begin
                cmd.put_byte = 1'b1;
                cmd.src      = BSRC_ZERO;
                if (fin_reg) begin
                    // first padding byte after the message
                    cmd.src       = BSRC_PAD;
                    cmd.latch_len = 1'b1;
                    fin_next      = 1'b0;
                    if (sts.pos == 6'd55) begin
                        lenw_next = 1'b1;
                    end
                end else if (lenw_reg) begin
                    cmd.src = BSRC_LEN;
                end else if (sts.pos == 6'd55) begin
                    lenw_next = 1'b1;
                end
                if (sts.pos == 6'd63) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.comp_start = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.comp_round = 1'b1;
                if (sts.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.comp_add = 1'b1;
                if (lenw_reg) begin
                    idx_next   = '0;
                    mv_next    = 1'b1;
                    pad_next   = 1'b0;
                    state_next = ST_OUT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (m_last_word) begin
                        mv_next     = 1'b0;
                        lenw_next   = 1'b0;
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            lenw_reg  <= 1'b0;
            idx_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            lenw_reg  <= lenw_next;
            idx_reg   <= idx_next;
            mv_reg    <= mv_next;
        end
    end

    // Output valid only while presenting digest words
    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_OUT)
        else $error("digest shown outside output state");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND |=> !s_ready || $past(sts.round_last))
        else $error("item accepted during rounds");
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> idx_reg <= 3'(NumDigestWords - 1))
        else $error("digest word index out of range");

endmodule

>>> rtl/sha1_message_digest.sv
// SHA-1 over a byte stream. Each input item may carry one byte and may end the
// message; after the end item the block emits five 32-bit digest words, word 0
// first, the fifth flagged m_last_word, then restarts from the initial chaining
// values. Ordinary bytes are accepted back to back; every 64th byte, and
// the padding, costs one 80-round compression at one round per cycle,
// during which no item is accepted. A final item is further followed by
// the padding bytes and one or two compressions before the digest appears.
module sha1_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha1_pkg::*;

    sha1_cmd_t  cmd;
    sha1_sts_t  sts;
    logic [2:0] out_idx;

    sha1_control u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_word_index     (m_word_index),
        .m_last_word      (m_last_word),
        .cmd              (cmd),
        .sts              (sts),
        .out_idx          (out_idx)
    );

    sha1_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_data_byte),
        .out_idx     (out_idx),
        .sts         (sts),
        .digest_word (m_digest_word)
    );

endmodule
